// ===== hdl/assert_macros.svh =====
// Assertion macros used by the segment pair intersection RTL.
// Depends on nothing; the macros compile away when SYNTHESIS is defined.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define SPI_ASSERT(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);
`define SPI_NEVER(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) !(prop)) else $error(msg);
`else
`define SPI_ASSERT(lbl, clk, rst, prop, msg)
`define SPI_NEVER(lbl, clk, rst, prop, msg)
`endif
`endif

// ===== hdl/spi_pkg.sv =====
// Shared types and constants for the segment pair intersection core.
// Used by every module of the block but spi_div; depends on nothing.
package spi_pkg;

   localparam int STATUS_W = 3;
   localparam int THR_W = 32;
   localparam logic [THR_W-1:0] THR_RESET = 32'd1;

   typedef enum logic [STATUS_W-1:0] {
      ST_INTERSECT = 3'd0,
      ST_BOX_APART = 3'd1,
      ST_SHARED    = 3'd2,
      ST_PARALLEL  = 3'd3,
      ST_NONE      = 3'd4
   } status_type;

endpackage

// ===== hdl/spi_geom.sv =====
// Four stage front end: differences and box tests, cross products, sums and classification.
// Depends on spi_pkg.
module spi_geom #(
   parameter int CW = 16
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic [spi_pkg::THR_W-1:0] thr,
   input  logic                     in_valid,
   output logic                     in_ready,
   input  logic [8*CW-1:0]          in_data,
   output logic                     out_valid,
   input  logic                     out_ready,
   output spi_pkg::status_type      status,
   output logic signed [CW-1:0]     ax0,
   output logic signed [CW-1:0]     ay0,
   output logic signed [CW:0]       dax,
   output logic signed [CW:0]       day,
   output logic [2*CW+2:0]          num_a,
   output logic [2*CW+2:0]          num_b,
   output logic [2*CW+2:0]          mag
);
   localparam int DW = CW + 1;
   localparam int PW = 2 * DW;
   localparam int DEN_W = 2 * CW + 3;
   localparam int CMP_W = DEN_W + spi_pkg::THR_W;
   localparam int NS = 4;

   logic [NS-1:0] v_ff;
   logic [NS-1:0] adv;

   logic signed [CW-1:0] c_ax0, c_ay0, c_ax1, c_ay1, c_bx0, c_by0, c_bx1, c_by1;
   logic apart_in, shared_in;

   logic signed [CW-1:0] ax0_1_ff, ay0_1_ff, ax0_2_ff, ay0_2_ff, ax0_3_ff, ay0_3_ff;
   logic signed [DW-1:0] dax_1_ff, day_1_ff, dbx_1_ff, dby_1_ff, ox_1_ff, oy_1_ff;
   logic signed [DW-1:0] dax_2_ff, day_2_ff, dax_3_ff, day_3_ff;
   logic apart_1_ff, shared_1_ff, apart_2_ff, shared_2_ff, apart_3_ff, shared_3_ff;
   logic signed [PW-1:0] pd1_ff, pd2_ff, pa1_ff, pa2_ff, pb1_ff, pb2_ff;
   logic signed [DEN_W-1:0] den_ff, na_ff, nb_ff;

   logic [DEN_W-1:0] mag_in;
   logic signed [DEN_W-1:0] na_adj, nb_adj;
   spi_pkg::status_type status_in;

   spi_pkg::status_type status_ff;
   logic signed [CW-1:0] ax0_ff, ay0_ff;
   logic signed [DW-1:0] dax_ff, day_ff;
   logic [DEN_W-1:0] num_a_ff, num_b_ff, mag_ff;

   always_comb begin
      adv[NS-1] = !v_ff[NS-1] || out_ready;
      for (int k = NS - 2; k >= 0; k--) begin
         adv[k] = !v_ff[k] || adv[k+1];
      end
   end

   assign in_ready = adv[0];

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= '0;
      end else begin
         if (adv[0]) v_ff[0] <= in_valid;
         for (int k = 1; k < NS; k++) begin
            if (adv[k]) v_ff[k] <= v_ff[k-1];
         end
      end
   end

   assign c_ax0 = in_data[0*CW +: CW];
   assign c_ay0 = in_data[1*CW +: CW];
   assign c_ax1 = in_data[2*CW +: CW];
   assign c_ay1 = in_data[3*CW +: CW];
   assign c_bx0 = in_data[4*CW +: CW];
   assign c_by0 = in_data[5*CW +: CW];
   assign c_bx1 = in_data[6*CW +: CW];
   assign c_by1 = in_data[7*CW +: CW];

   function automatic logic apart_axis(input logic signed [CW-1:0] p0, input logic signed [CW-1:0] p1,
                                       input logic signed [CW-1:0] q0, input logic signed [CW-1:0] q1);
      logic signed [CW-1:0] plo, phi, qlo, qhi;
      plo = (p0 < p1) ? p0 : p1;
      phi = (p0 < p1) ? p1 : p0;
      qlo = (q0 < q1) ? q0 : q1;
      qhi = (q0 < q1) ? q1 : q0;
      return (phi < qlo) || (plo > qhi);
   endfunction

   assign apart_in = apart_axis(c_ax0, c_ax1, c_bx0, c_bx1) || apart_axis(c_ay0, c_ay1, c_by0, c_by1);
   assign shared_in = (c_bx0 == c_ax0 && c_by0 == c_ay0) || (c_bx0 == c_ax1 && c_by0 == c_ay1) ||
                      (c_bx1 == c_ax0 && c_by1 == c_ay0) || (c_bx1 == c_ax1 && c_by1 == c_ay1);

   always_ff @(posedge clock) begin
      if (adv[0]) begin
         ax0_1_ff    <= c_ax0;
         ay0_1_ff    <= c_ay0;
         dax_1_ff    <= DW'(c_ax1) - DW'(c_ax0);
         day_1_ff    <= DW'(c_ay1) - DW'(c_ay0);
         dbx_1_ff    <= DW'(c_bx1) - DW'(c_bx0);
         dby_1_ff    <= DW'(c_by1) - DW'(c_by0);
         ox_1_ff     <= DW'(c_ax0) - DW'(c_bx0);
         oy_1_ff     <= DW'(c_ay0) - DW'(c_by0);
         apart_1_ff  <= apart_in;
         shared_1_ff <= shared_in;
      end
      if (adv[1]) begin
         pd1_ff      <= dax_1_ff * dby_1_ff;
         pd2_ff      <= day_1_ff * dbx_1_ff;
         pa1_ff      <= oy_1_ff * dbx_1_ff;
         pa2_ff      <= ox_1_ff * dby_1_ff;
         pb1_ff      <= oy_1_ff * dax_1_ff;
         pb2_ff      <= ox_1_ff * day_1_ff;
         ax0_2_ff    <= ax0_1_ff;
         ay0_2_ff    <= ay0_1_ff;
         dax_2_ff    <= dax_1_ff;
         day_2_ff    <= day_1_ff;
         apart_2_ff  <= apart_1_ff;
         shared_2_ff <= shared_1_ff;
      end
      if (adv[2]) begin
         den_ff      <= DEN_W'(pd1_ff) - DEN_W'(pd2_ff);
         na_ff       <= DEN_W'(pa1_ff) - DEN_W'(pa2_ff);
         nb_ff       <= DEN_W'(pb1_ff) - DEN_W'(pb2_ff);
         ax0_3_ff    <= ax0_2_ff;
         ay0_3_ff    <= ay0_2_ff;
         dax_3_ff    <= dax_2_ff;
         day_3_ff    <= day_2_ff;
         apart_3_ff  <= apart_2_ff;
         shared_3_ff <= shared_2_ff;
      end
      if (adv[3]) begin
         status_ff <= status_in;
         ax0_ff    <= ax0_3_ff;
         ay0_ff    <= ay0_3_ff;
         dax_ff    <= dax_3_ff;
         day_ff    <= day_3_ff;
         num_a_ff  <= DEN_W'(na_adj);
         num_b_ff  <= DEN_W'(nb_adj);
         mag_ff    <= mag_in;
      end
   end

   always_comb begin
      mag_in = den_ff[DEN_W-1] ? DEN_W'(-den_ff) : DEN_W'(den_ff);
      na_adj = den_ff[DEN_W-1] ? -na_ff : na_ff;
      nb_adj = den_ff[DEN_W-1] ? -nb_ff : nb_ff;
      priority if (apart_3_ff) begin
         status_in = spi_pkg::ST_BOX_APART;
      end else if (shared_3_ff) begin
         status_in = spi_pkg::ST_SHARED;
      end else if (den_ff == '0 || CMP_W'(mag_in) < CMP_W'(thr)) begin
         status_in = spi_pkg::ST_PARALLEL;
      end else if (na_adj[DEN_W-1] || DEN_W'(na_adj) > mag_in ||
                   nb_adj[DEN_W-1] || DEN_W'(nb_adj) > mag_in) begin
         status_in = spi_pkg::ST_NONE;
      end else begin
         status_in = spi_pkg::ST_INTERSECT;
      end
   end

   assign out_valid = v_ff[NS-1];
   assign status = status_ff;
   assign ax0 = ax0_ff;
   assign ay0 = ay0_ff;
   assign dax = dax_ff;
   assign day = day_ff;
   assign num_a = num_a_ff;
   assign num_b = num_b_ff;
   assign mag = mag_ff;

endmodule

// ===== hdl/spi_div.sv =====
// Pipelined restoring divider with two lanes sharing one divisor, one quotient bit per stage.
// Carries a sideband word alongside; depends on nothing outside this file.
module spi_div #(
   parameter int CW = 16,
   parameter int PFB = 16,
   parameter int SB_W = 8
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             in_valid,
   output logic             in_ready,
   input  logic [2*CW+2:0]  num_a,
   input  logic [2*CW+2:0]  num_b,
   input  logic [2*CW+2:0]  mag,
   input  logic [SB_W-1:0]  sb_in,
   output logic             out_valid,
   input  logic             out_ready,
   output logic [PFB:0]     q_a,
   output logic [PFB:0]     q_b,
   output logic [SB_W-1:0]  sb_out
);
   localparam int DEN_W = 2 * CW + 3;
   localparam int REM_W = DEN_W + 1;
   localparam int QW = PFB + 1;
   localparam int NS = PFB + 1;

   logic [NS-1:0] v_ff;
   logic [NS-1:0] adv;
   logic [REM_W-1:0] rem_a_ff [NS];
   logic [REM_W-1:0] rem_b_ff [NS];
   logic [QW-1:0] q_a_ff [NS];
   logic [QW-1:0] q_b_ff [NS];
   logic [REM_W-1:0] mag_ff [NS];
   logic [SB_W-1:0] sb_ff [NS];

   always_comb begin
      adv[NS-1] = !v_ff[NS-1] || out_ready;
      for (int k = NS - 2; k >= 0; k--) begin
         adv[k] = !v_ff[k] || adv[k+1];
      end
   end

   assign in_ready = adv[0];

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= '0;
      end else begin
         if (adv[0]) v_ff[0] <= in_valid;
         for (int k = 1; k < NS; k++) begin
            if (adv[k]) v_ff[k] <= v_ff[k-1];
         end
      end
   end

   for (genvar s = 0; s < NS; s++) begin : g_stage
      logic [REM_W-1:0] ra, rb, dv;
      logic [QW-1:0] qa_prev, qb_prev;
      logic [SB_W-1:0] sb_prev;
      logic ba, bb;

      always_comb begin
         if (s == 0) begin
            ra = REM_W'(num_a);
            rb = REM_W'(num_b);
            dv = REM_W'(mag);
            qa_prev = '0;
            qb_prev = '0;
            sb_prev = sb_in;
         end else begin
            ra = {rem_a_ff[(s == 0) ? 0 : s-1][REM_W-2:0], 1'b0};
            rb = {rem_b_ff[(s == 0) ? 0 : s-1][REM_W-2:0], 1'b0};
            dv = mag_ff[(s == 0) ? 0 : s-1];
            qa_prev = q_a_ff[(s == 0) ? 0 : s-1];
            qb_prev = q_b_ff[(s == 0) ? 0 : s-1];
            sb_prev = sb_ff[(s == 0) ? 0 : s-1];
         end
         ba = ra >= dv;
         bb = rb >= dv;
      end

      always_ff @(posedge clock) begin
         if (adv[s]) begin
            rem_a_ff[s] <= ba ? ra - dv : ra;
            rem_b_ff[s] <= bb ? rb - dv : rb;
            q_a_ff[s]   <= {qa_prev[QW-2:0], ba};
            q_b_ff[s]   <= {qb_prev[QW-2:0], bb};
            mag_ff[s]   <= dv;
            sb_ff[s]    <= sb_prev;
         end
      end
   end

   assign out_valid = v_ff[NS-1];
   assign q_a = q_a_ff[NS-1];
   assign q_b = q_b_ff[NS-1];
   assign sb_out = sb_ff[NS-1];

endmodule

// ===== hdl/spi_point.sv =====
// Two stage back end: scales the first direction by its parameter, then forms the result beat.
// Depends on spi_pkg.
module spi_point #(
   parameter int CW = 16,
   parameter int PFB = 16
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 in_valid,
   output logic                 in_ready,
   input  spi_pkg::status_type  status_in,
   input  logic signed [CW-1:0] ax0,
   input  logic signed [CW-1:0] ay0,
   input  logic signed [CW:0]   dax,
   input  logic signed [CW:0]   day,
   input  logic [PFB:0]         q_a,
   input  logic [PFB:0]         q_b,
   output logic                 out_valid,
   input  logic                 out_ready,
   output spi_pkg::status_type  status,
   output logic [PFB:0]         alpha_a,
   output logic [PFB:0]         alpha_b,
   output logic signed [CW-1:0] cross_x,
   output logic signed [CW-1:0] cross_y
);
   localparam int QW = PFB + 1;
   localparam int MW = CW + 1 + QW + 1;

   logic [1:0] v_ff;
   logic [1:0] adv;
   logic signed [MW-1:0] px_ff, py_ff;
   logic signed [CW-1:0] ax0_ff, ay0_ff;
   logic [QW-1:0] qa_ff, qb_ff;
   spi_pkg::status_type st_ff;
   logic hit;

   spi_pkg::status_type status_ff;
   logic [QW-1:0] alpha_a_ff, alpha_b_ff;
   logic signed [CW-1:0] cross_x_ff, cross_y_ff;

   assign adv[1] = !v_ff[1] || out_ready;
   assign adv[0] = !v_ff[0] || adv[1];
   assign in_ready = adv[0];

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= '0;
      end else begin
         if (adv[0]) v_ff[0] <= in_valid;
         if (adv[1]) v_ff[1] <= v_ff[0];
      end
   end

   assign hit = st_ff == spi_pkg::ST_INTERSECT;

   always_ff @(posedge clock) begin
      if (adv[0]) begin
         px_ff  <= MW'(dax) * $signed({1'b0, q_a});
         py_ff  <= MW'(day) * $signed({1'b0, q_a});
         ax0_ff <= ax0;
         ay0_ff <= ay0;
         qa_ff  <= q_a;
         qb_ff  <= q_b;
         st_ff  <= status_in;
      end
      if (adv[1]) begin
         status_ff  <= st_ff;
         alpha_a_ff <= hit ? qa_ff : '0;
         alpha_b_ff <= hit ? qb_ff : '0;
         cross_x_ff <= hit ? ax0_ff + CW'(px_ff >>> PFB) : '0;
         cross_y_ff <= hit ? ay0_ff + CW'(py_ff >>> PFB) : '0;
      end
   end

   assign out_valid = v_ff[1];
   assign status = status_ff;
   assign alpha_a = alpha_a_ff;
   assign alpha_b = alpha_b_ff;
   assign cross_x = cross_x_ff;
   assign cross_y = cross_y_ff;

endmodule

// ===== hdl/segment_pair_intersect_core.sv =====
// Segment pair intersection core: each accepted request beat passes through the front end,
// the divider and the back end to its response beat; one beat per cycle sustained while
// rsp_tready is held high. The divider resolves one quotient bit per stage.
// Any stage may hold a beat under backpressure; empty stages still fill.
// Synchronous active-high reset empties the pipeline and sets the threshold to 1.
`include "assert_macros.svh"
module segment_pair_intersect_core #(
   parameter int COORD_WIDTH = 16,
   parameter int PARAM_FRAC_BITS = 16
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_tvalid,
   output logic                          req_tready,
   // a_start_x, a_start_y, a_end_x, a_end_y, b_start_x, b_start_y, b_end_x, b_end_y
   input  logic [8*COORD_WIDTH-1:0]      req_tdata,
   output logic                          rsp_tvalid,
   input  logic                          rsp_tready,
   // status, alpha_a, alpha_b, cross_x, cross_y, zero fill
   output logic [((2*COORD_WIDTH+2*PARAM_FRAC_BITS+5+7)/8)*8-1:0] rsp_tdata,
   input  logic                          csr_we,
   input  logic [spi_pkg::THR_W-1:0]     csr_wdata
);
   localparam int CW = COORD_WIDTH;
   localparam int PFB = PARAM_FRAC_BITS;
   localparam int DEN_W = 2 * CW + 3;
   localparam int OUT_BITS = ((2 * CW + 2 * PFB + 5 + 7) / 8) * 8;
   localparam int SB_W = spi_pkg::STATUS_W + 2 * CW + 2 * (CW + 1);

   logic [spi_pkg::THR_W-1:0] thr_ff;

   logic g_valid, g_ready;
   spi_pkg::status_type g_status;
   logic signed [CW-1:0] g_ax0, g_ay0;
   logic signed [CW:0] g_dax, g_day;
   logic [DEN_W-1:0] g_num_a, g_num_b, g_mag;

   logic d_valid, d_ready;
   logic [PFB:0] d_qa, d_qb;
   logic [SB_W-1:0] d_sb;

   spi_pkg::status_type o_status;
   logic [PFB:0] o_alpha_a, o_alpha_b;
   logic signed [CW-1:0] o_cross_x, o_cross_y;

   always_ff @(posedge clock) begin
      if (reset) begin
         thr_ff <= spi_pkg::THR_RESET;
      end else if (csr_we) begin
         thr_ff <= csr_wdata;
      end
   end

   spi_geom #(.CW(CW)) u_geom (
      .clock(clock), .reset(reset), .thr(thr_ff),
      .in_valid(req_tvalid), .in_ready(req_tready), .in_data(req_tdata),
      .out_valid(g_valid), .out_ready(g_ready),
      .status(g_status), .ax0(g_ax0), .ay0(g_ay0), .dax(g_dax), .day(g_day),
      .num_a(g_num_a), .num_b(g_num_b), .mag(g_mag)
   );

   spi_div #(.CW(CW), .PFB(PFB), .SB_W(SB_W)) u_div (
      .clock(clock), .reset(reset),
      .in_valid(g_valid), .in_ready(g_ready),
      .num_a(g_num_a), .num_b(g_num_b), .mag(g_mag),
      .sb_in({g_day, g_dax, g_ay0, g_ax0, g_status}),
      .out_valid(d_valid), .out_ready(d_ready),
      .q_a(d_qa), .q_b(d_qb), .sb_out(d_sb)
   );

   spi_point #(.CW(CW), .PFB(PFB)) u_point (
      .clock(clock), .reset(reset),
      .in_valid(d_valid), .in_ready(d_ready),
      .status_in(spi_pkg::status_type'(d_sb[spi_pkg::STATUS_W-1:0])),
      .ax0(d_sb[spi_pkg::STATUS_W +: CW]),
      .ay0(d_sb[spi_pkg::STATUS_W + CW +: CW]),
      .dax(d_sb[spi_pkg::STATUS_W + 2*CW +: CW+1]),
      .day(d_sb[spi_pkg::STATUS_W + 3*CW + 1 +: CW+1]),
      .q_a(d_qa), .q_b(d_qb),
      .out_valid(rsp_tvalid), .out_ready(rsp_tready),
      .status(o_status), .alpha_a(o_alpha_a), .alpha_b(o_alpha_b),
      .cross_x(o_cross_x), .cross_y(o_cross_y)
   );

   assign rsp_tdata = OUT_BITS'({o_cross_y, o_cross_x, o_alpha_b, o_alpha_a, o_status});

   `SPI_ASSERT(a_zero_fields, clock, reset, (rsp_tvalid && o_status != spi_pkg::ST_INTERSECT) |-> (o_alpha_a == '0 && o_alpha_b == '0 && o_cross_x == '0 && o_cross_y == '0), "nonzero fields on a miss")
   `SPI_ASSERT(a_alpha_range, clock, reset, (rsp_tvalid && o_status == spi_pkg::ST_INTERSECT) |-> (o_alpha_a[PFB] == 1'b0 || o_alpha_a[PFB-1:0] == '0), "alpha_a above one")
   `SPI_NEVER(a_empty_stall, clock, reset, !rsp_tvalid && !d_ready, "back end stalls while empty")

endmodule

// ===== verif/segment_pair_intersect_core_test.sv =====
// Self-checking testbench for segment_pair_intersect_core: drives segment pairs on the
// request stream, predicts each classification and compares every response beat.
// Depends on spi_pkg and the core RTL only.
`timescale 1ns / 1ps
module segment_pair_intersect_core_test;

   localparam int CW = 16;
   localparam int PFB = 16;
   localparam int RSP_W = ((2*CW+2*PFB+5+7)/8)*8;
   localparam int LATENCY = PFB + 7;
   localparam int STALL_LIMIT = 20000;
   localparam int HOLD_CYCLES = 400;

   typedef struct packed {
      logic signed [CW-1:0] bey, bex, bsy, bsx, aey, aex, asy, asx;
   } seg_pair_type;

   typedef struct {
      spi_pkg::status_type status;
      logic [PFB:0] alpha_a, alpha_b;
      logic signed [CW-1:0] cross_x, cross_y;
   } verdict_type;

   logic clock = 0, reset = 1;
   logic req_tvalid = 0, req_tready;
   logic [8*CW-1:0] req_tdata = '0;
   logic rsp_tvalid, rsp_tready = 0;
   logic [RSP_W-1:0] rsp_tdata;
   logic csr_we = 0;
   logic [spi_pkg::THR_W-1:0] csr_wdata = '0;

   segment_pair_intersect_core i_dut (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready), .req_tdata(req_tdata),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready), .rsp_tdata(rsp_tdata),
      .csr_we(csr_we), .csr_wdata(csr_wdata)
   );

   initial begin
      forever #4 clock = ~clock;
   end

   seg_pair_type pending_pairs[$];
   verdict_type expected_verdicts[$];
   logic [spi_pkg::THR_W-1:0] threshold = spi_pkg::THR_RESET;
   int errors = 0, beats_in = 0, beats_out = 0, idle_cycles = 0;
   int hits[5] = '{default: 0};
   bit hold_rsp = 0, allow_send = 1;

   function automatic bit overlaps(longint p0, longint p1, longint q0, longint q1);
      longint plo, phi, qlo, qhi;
      plo = p0 < p1 ? p0 : p1;
      phi = p0 < p1 ? p1 : p0;
      qlo = q0 < q1 ? q0 : q1;
      qhi = q0 < q1 ? q1 : q0;
      return !(phi < qlo || plo > qhi);
   endfunction

   function automatic longint floor_frac(longint v);
      return v >>> PFB;
   endfunction

   function automatic verdict_type classify_pair(seg_pair_type p);
      verdict_type v;
      longint ax0, ay0, ax1, ay1, bx0, by0, bx1, by1;
      longint dax, day, dbx, dby, den, mag, ox, oy, na, nb, ta, tb;
      ax0 = p.asx; ay0 = p.asy; ax1 = p.aex; ay1 = p.aey;
      bx0 = p.bsx; by0 = p.bsy; bx1 = p.bex; by1 = p.bey;
      v.status = spi_pkg::ST_INTERSECT;
      v.alpha_a = '0; v.alpha_b = '0; v.cross_x = '0; v.cross_y = '0;
      if (!overlaps(ax0, ax1, bx0, bx1) || !overlaps(ay0, ay1, by0, by1)) begin
         v.status = spi_pkg::ST_BOX_APART;
      end else if ((bx0 == ax0 && by0 == ay0) || (bx0 == ax1 && by0 == ay1) ||
            (bx1 == ax0 && by1 == ay0) || (bx1 == ax1 && by1 == ay1)) begin
         v.status = spi_pkg::ST_SHARED;
      end else begin
         dax = ax1 - ax0; day = ay1 - ay0; dbx = bx1 - bx0; dby = by1 - by0;
         den = dax * dby - day * dbx;
         mag = den < 0 ? -den : den;
         if (den == 0 || mag < longint'(threshold)) begin
            v.status = spi_pkg::ST_PARALLEL;
         end else begin
            ox = ax0 - bx0; oy = ay0 - by0;
            na = oy * dbx - ox * dby;
            nb = oy * dax - ox * day;
            if (den < 0) begin
               na = -na; nb = -nb;
            end
            if (na < 0 || na > mag || nb < 0 || nb > mag) begin
               v.status = spi_pkg::ST_NONE;
            end else begin
               ta = (na <<< PFB) / mag;
               tb = (nb <<< PFB) / mag;
               v.alpha_a = ta[PFB:0];
               v.alpha_b = tb[PFB:0];
               v.cross_x = CW'(ax0 + floor_frac(dax * ta));
               v.cross_y = CW'(ay0 + floor_frac(day * ta));
            end
         end
      end
      return v;
   endfunction

   task automatic report_mismatch(string what, longint got, longint want);
      errors++;
      $display("mismatch on beat %0d: %s got %0d expected %0d", beats_out, what, got, want);
   endtask

   // Sender: random bursts and gaps, refilled from the pending queue.
   int burst_left = 0, gap_left = 0;
   always @(posedge clock) begin
      if (!reset) begin
         if (req_tvalid && req_tready) begin
            expected_verdicts = {expected_verdicts,
                                 classify_pair(seg_pair_type'(req_tdata))};
            void'(pending_pairs.pop_front());
            beats_in++;
         end
         if (req_tvalid && !(req_tready)) begin
            // Beat stays on the bus until taken.
         end else if (gap_left > 0) begin
            gap_left <= gap_left - 1;
            req_tvalid <= 0;
         end else if (allow_send && pending_pairs.size() > 0) begin
            req_tvalid <= 1;
            req_tdata <= pending_pairs[0];
            if (burst_left <= 1) begin
               burst_left <= $urandom_range(1, 40);
               gap_left <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 6);
            end else begin
               burst_left <= burst_left - 1;
            end
         end else begin
            req_tvalid <= 0;
         end
      end
   end

   // Receiver: own stall pattern plus one long hold-off that it counts itself.
   int stall_mode = 0;
   int hold_left = 0;
   bit hold_seen = 0;
   always @(posedge clock) begin
      if ($urandom_range(0, 199) == 0) stall_mode <= $urandom_range(0, 2);
      if (hold_rsp && !hold_seen) begin
         hold_seen <= 1;
         hold_left <= HOLD_CYCLES;
         rsp_tready <= 0;
      end else if (hold_left > 0) begin
         hold_left <= hold_left - 1;
         rsp_tready <= 0;
      end else begin
         unique case (stall_mode)
            0: rsp_tready <= 1;
            1: rsp_tready <= $urandom_range(0, 3) != 0;
            default: rsp_tready <= $urandom_range(0, 3) == 0;
         endcase
      end
   end

   // Monitor and watchdog.
   always @(posedge clock) begin
      verdict_type w;
      spi_pkg::status_type got_st;
      if (!reset) begin
         if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) idle_cycles <= 0;
         else idle_cycles <= idle_cycles + 1;
         if (idle_cycles > STALL_LIMIT) begin
            $display("watchdog: no beat for %0d cycles", STALL_LIMIT);
            $display("segment_pair_intersect_core_test NOT OK");
            $finish;
         end
         if (rsp_tvalid && rsp_tready) begin
            beats_out++;
            got_st = spi_pkg::status_type'(rsp_tdata[2:0]);
            if (expected_verdicts.size() == 0) begin
               report_mismatch("unexpected beat status", got_st, -1);
            end else begin
               w = expected_verdicts.pop_front();
               hits[w.status]++;
               if (got_st !== w.status) report_mismatch("status", got_st, w.status);
               if (rsp_tdata[3 +: PFB+1] !== w.alpha_a)
                  report_mismatch("alpha_a", rsp_tdata[3 +: PFB+1], w.alpha_a);
               if (rsp_tdata[4+PFB +: PFB+1] !== w.alpha_b)
                  report_mismatch("alpha_b", rsp_tdata[4+PFB +: PFB+1], w.alpha_b);
               if (rsp_tdata[5+2*PFB +: CW] !== w.cross_x)
                  report_mismatch("cross_x", rsp_tdata[5+2*PFB +: CW], w.cross_x);
               if (rsp_tdata[5+2*PFB+CW +: CW] !== w.cross_y)
                  report_mismatch("cross_y", rsp_tdata[5+2*PFB+CW +: CW], w.cross_y);
            end
         end
      end
   end

   function automatic logic signed [CW-1:0] rand_coord(int span);
      if (span == 0) return CW'($urandom);
      return CW'($signed($urandom_range(0, 2*span)) - span);
   endfunction

   function automatic seg_pair_type random_pair();
      seg_pair_type p;
      int kind, span;
      kind = $urandom_range(0, 9);
      span = ($urandom_range(0, 2) == 0) ? 0 : (($urandom_range(0, 1) == 0) ? 64 : 2000);
      p = seg_pair_type'({$urandom, $urandom, $urandom, $urandom});
      if (span != 0) begin
         p.asx = rand_coord(span); p.asy = rand_coord(span);
         p.aex = rand_coord(span); p.aey = rand_coord(span);
         p.bsx = rand_coord(span); p.bsy = rand_coord(span);
         p.bex = rand_coord(span); p.bey = rand_coord(span);
      end
      unique case (kind)
         0: begin p.bsx = p.aex; p.bsy = p.aey; end
         1: begin p.bex = p.asx + (p.aex - p.asx); p.bey = p.bsy + (p.aey - p.asy);
            p.bex = p.bsx + (p.aex - p.asx); end
         2: begin p.bex = p.bsx; p.bey = p.bsy; end
         3: begin
            p.bsx = p.asx + ((p.aex - p.asx) >>> 1);
            p.bsy = p.asy + ((p.aey - p.asy) >>> 1);
         end
         default: ;
      endcase
      return p;
   endfunction

   task automatic drain();
      while (pending_pairs.size() > 0 || req_tvalid || expected_verdicts.size() > 0)
         @(posedge clock);
      repeat (LATENCY + 4) @(posedge clock);
   endtask

   task automatic write_threshold(logic [spi_pkg::THR_W-1:0] val);
      csr_we <= 1;
      csr_wdata <= val;
      @(posedge clock);
      csr_we <= 0;
      threshold = val;
   endtask

   task automatic add_pair(int ax0, int ay0, int ax1, int ay1, int bx0, int by0, int bx1, int by1);
      seg_pair_type p;
      p.asx = CW'(ax0); p.asy = CW'(ay0); p.aex = CW'(ax1); p.aey = CW'(ay1);
      p.bsx = CW'(bx0); p.bsy = CW'(by0); p.bex = CW'(bx1); p.bey = CW'(by1);
      pending_pairs = {pending_pairs, p};
   endtask

   logic [spi_pkg::THR_W-1:0] settings[5] = '{32'd1, 32'd0, 32'd300, 32'hFFFF_FFFF, 32'd100000};

   initial begin
      repeat (10) @(posedge clock);
      reset <= 0;
      @(posedge clock);
      // Directed: crossing, apart, shared endpoint, parallel, miss, extremes, endpoint params.
      add_pair(0, 0, 160, 160, 0, 160, 160, 0);
      add_pair(0, 0, 16, 16, 100, 100, 200, 200);
      add_pair(0, 0, 160, 160, 160, 160, 320, 0);
      add_pair(0, 0, 160, 0, 0, 16, 160, 16);
      add_pair(0, 0, 160, 0, 0, 0, 160, 0);
      add_pair(0, 0, 160, 160, 150, 0, 160, 20);
      add_pair(-32768, -32768, 32767, 32767, -32768, 32767, 32767, -32768);
      add_pair(32767, -32768, -32768, 32767, -32768, -32768, 32767, 32767);
      add_pair(0, 0, 160, 0, 80, 0, 80, 160);
      add_pair(0, 0, 160, 0, 160, -16, 160, 16);
      add_pair(5, 5, 5, 5, 0, 0, 16, 16);
      add_pair(-1, -1, -32768, 32767, 32767, -32768, -16, -16);
      add_pair(1, 2, 3, 1, 1, 1, 3, 3);
      add_pair(-7, 3, 9, -5, -3, -6, 4, 8);
      drain();
      foreach (settings[s]) begin
         write_threshold(settings[s]);
         repeat (300) pending_pairs = {pending_pairs, random_pair()};
         if (s == 2) begin
            hold_rsp = 1;
            @(posedge clock);
            wait (hold_seen && hold_left == 0);
         end
         if (s == 3) begin
            repeat (100) @(posedge clock);
            allow_send = 0;
            while (expected_verdicts.size() > 0) @(posedge clock);
            allow_send = 1;
         end
         drain();
      end
      $display("checked %0d beats, %0d pairs sent; intersect %0d apart %0d shared %0d",
         beats_out, beats_in, hits[0], hits[1], hits[2]);
      $display("parallel %0d miss %0d over five threshold settings", hits[3], hits[4]);
      if (errors == 0) begin
         $display("segment_pair_intersect_core_test OK");
      end else begin
         $display("segment_pair_intersect_core_test NOT OK");
      end
      $finish;
   end
endmodule
